// File: rtl/drr_pkg.sv
// Shared types and constants for the deferred release ring.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package drr_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int OP_W           = 2;
    localparam int HANDLE_W       = 32;
    localparam int DELAY_W        = 8;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

endpackage : drr_pkg

`default_nettype wire

// File: rtl/drr_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies; used for the handle store and the delay counts.
`default_nettype none

module drr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : drr_ram

`default_nettype wire

// File: rtl/deferred_release_ring.sv
// Deferred release ring: top level with its walk sequencer.
// Depends on drr_pkg and two drr_ram instances.
//
// Usage:
//   Command channel: an item (i_operation, i_handle) is taken at a rising edge
//   with start high and busy low. Insert and clear finish at that edge and
//   leave busy low, so they can be issued every cycle. An insert into a full
//   ring shows its dropped beat on the cycle right after it was taken.
//   A tick walks slots from the read position to the insert position (the
//   whole ring when they match), one slot per cycle through the shared
//   decrement unit and the count RAM port. A walk covers 1 to RING_DEPTH
//   slots and busy stays high throughout; the final beat, with o_last set,
//   appears in the first cycle with busy low again. A tick that finds the
//   read slot empty finishes at its accepting edge.
//   Result channel: each beat is shown for one cycle with o_valid high; the
//   receiver cannot stall it. Configuration: i_cfg_we writes release_delay
//   (0 acts as 1); the user must assert it only while idle, which the block
//   does not enforce. Reset (synchronous, active low) empties the ring, zeroes
//   both positions and sets release_delay to 2. No clearing pass is needed.
`default_nettype none

module deferred_release_ring #(
    parameter int RING_DEPTH = drr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [drr_pkg::OP_W-1:0]      i_operation,
    input  wire logic [drr_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic                          i_cfg_we,
    input  wire logic [drr_pkg::DELAY_W-1:0]   i_cfg_wdata,
    output logic                               o_valid,
    output logic      [drr_pkg::HANDLE_W-1:0]  o_released_handle,
    output logic                               o_dropped,
    output logic                               o_last
);

    import drr_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [RING_DEPTH-1:0] r_valid, n_valid;
    logic [AW-1:0]         r_ins_idx, n_ins_idx;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic [AW-1:0]         r_rd_pos, n_rd_pos;
    logic [SW-1:0]         r_steps, n_steps;
    logic                  r_issuing, n_issuing;
    logic                  r_ex_vld, n_ex_vld;
    logic [AW-1:0]         r_ex_pos, n_ex_pos;
    logic                  r_ex_occ, n_ex_occ;
    logic                  r_pend_vld, n_pend_vld;
    logic [HANDLE_W-1:0]   r_pend_handle, n_pend_handle;
    logic [DELAY_W-1:0]    r_release_delay, n_release_delay;
    logic                  r_out_stb, n_out_stb;
    logic [HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic                  r_out_dropped, n_out_dropped;
    logic                  r_out_last, n_out_last;

    logic                  w_accept;
    logic                  w_full;
    logic [DELAY_W-1:0]    w_delay;
    logic [AW-1:0]         w_rd_next;
    logic                  w_cnt_we;
    logic [AW-1:0]         w_cnt_waddr;
    logic [DELAY_W-1:0]    w_cnt_wdata;
    logic [DELAY_W-1:0]    w_cnt_q;
    logic                  w_hdl_we;
    logic [HANDLE_W-1:0]   w_hdl_q;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_full    = (r_ins_idx == r_rd_idx) && r_valid[r_rd_idx];
    assign w_delay   = (r_release_delay == '0) ? DELAY_W'(1) : r_release_delay;
    assign w_rd_next = f_next(r_rd_pos);

    always_comb begin
        n_state         = r_state;
        n_valid         = r_valid;
        n_ins_idx       = r_ins_idx;
        n_rd_idx        = r_rd_idx;
        n_rd_pos        = r_rd_pos;
        n_steps         = r_steps;
        n_issuing       = r_issuing;
        n_ex_vld        = 1'b0;
        n_ex_pos        = r_ex_pos;
        n_ex_occ        = r_ex_occ;
        n_pend_vld      = r_pend_vld;
        n_pend_handle   = r_pend_handle;
        n_release_delay = i_cfg_we ? i_cfg_wdata : r_release_delay;
        n_out_stb       = 1'b0;
        n_out_handle    = r_out_handle;
        n_out_dropped   = r_out_dropped;
        n_out_last      = r_out_last;
        w_cnt_we        = 1'b0;
        w_cnt_waddr     = r_ins_idx;
        w_cnt_wdata     = w_delay;
        w_hdl_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_INSERT: begin
                            if (i_handle != '0) begin
                                if (w_full) begin
                                    n_out_stb     = 1'b1;
                                    n_out_handle  = i_handle;
                                    n_out_dropped = 1'b1;
                                    n_out_last    = 1'b1;
                                end else begin
                                    w_hdl_we             = 1'b1;
                                    w_cnt_we             = 1'b1;
                                    n_valid[r_ins_idx]   = 1'b1;
                                    n_ins_idx            = f_next(r_ins_idx);
                                end
                            end
                        end
                        OP_TICK: begin
                            // empty read slot: nothing to walk
                            if (r_valid[r_rd_idx]) begin
                                n_state    = S_WALK;
                                n_rd_pos   = r_rd_idx;
                                n_steps    = '0;
                                n_issuing  = 1'b1;
                                n_pend_vld = 1'b0;
                            end
                        end
                        OP_CLEAR: begin
                            n_valid   = '0;
                            n_ins_idx = '0;
                            n_rd_idx  = '0;
                        end
                        default: ;
                    endcase
                end
            end

            S_WALK: begin
                // issue stage: read the next slot
                if (r_issuing) begin
                    n_ex_vld  = 1'b1;
                    n_ex_pos  = r_rd_pos;
                    n_ex_occ  = r_valid[r_rd_pos];
                    n_rd_pos  = w_rd_next;
                    n_steps   = r_steps + SW'(1);
                    n_issuing = (w_rd_next != r_ins_idx)
                                && ((r_steps + SW'(1)) < SW'(RING_DEPTH));
                end
                // execute stage: decrement, release on reaching zero
                if (r_ex_vld && r_ex_occ) begin
                    w_cnt_we    = 1'b1;
                    w_cnt_waddr = r_ex_pos;
                    w_cnt_wdata = w_cnt_q - DELAY_W'(1);
                    if (w_cnt_q == DELAY_W'(1)) begin
                        n_valid[r_ex_pos] = 1'b0;
                        n_rd_idx          = f_next(r_ex_pos);
                        n_pend_vld        = 1'b1;
                        n_pend_handle     = w_hdl_q;
                        // hold one beat back so the final one can carry last
                        if (r_pend_vld) begin
                            n_out_stb     = 1'b1;
                            n_out_handle  = r_pend_handle;
                            n_out_dropped = 1'b0;
                            n_out_last    = 1'b0;
                        end
                    end
                end
                if (r_ex_vld && !r_issuing) begin
                    n_state = S_FLUSH;
                end
            end

            S_FLUSH: begin
                if (r_pend_vld) begin
                    n_out_stb     = 1'b1;
                    n_out_handle  = r_pend_handle;
                    n_out_dropped = 1'b0;
                    n_out_last    = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_valid         <= '0;
            r_ins_idx       <= '0;
            r_rd_idx        <= '0;
            r_issuing       <= 1'b0;
            r_ex_vld        <= 1'b0;
            r_pend_vld      <= 1'b0;
            r_release_delay <= DELAY_RESET;
            r_out_stb       <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_valid         <= n_valid;
            r_ins_idx       <= n_ins_idx;
            r_rd_idx        <= n_rd_idx;
            r_issuing       <= n_issuing;
            r_ex_vld        <= n_ex_vld;
            r_pend_vld      <= n_pend_vld;
            r_release_delay <= n_release_delay;
            r_out_stb       <= n_out_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos      <= n_rd_pos;
        r_steps       <= n_steps;
        r_ex_pos      <= n_ex_pos;
        r_ex_occ      <= n_ex_occ;
        r_pend_handle <= n_pend_handle;
        r_out_handle  <= n_out_handle;
        r_out_dropped <= n_out_dropped;
        r_out_last    <= n_out_last;
    end

    drr_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (RING_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_rd_pos),
        .o_rdata (w_cnt_q)
    );

    drr_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (RING_DEPTH)
    ) u_hdl_ram (
        .i_clk   (i_clk),
        .i_we    (w_hdl_we),
        .i_waddr (r_ins_idx),
        .i_wdata (i_handle),
        .i_raddr (r_rd_pos),
        .o_rdata (w_hdl_q)
    );

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_out_stb;
    assign o_released_handle = r_out_handle;
    assign o_dropped         = r_out_dropped;
    assign o_last            = r_out_last;

endmodule : deferred_release_ring

`default_nettype wire

// File: rtl/drr_chk.sv
// Port-level checker for deferred_release_ring, bound to the top level.
// Depends on drr_pkg for the operation codes.
`default_nettype none

module drr_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [drr_pkg::OP_W-1:0]      i_operation,
    input wire logic                          o_valid,
    input wire logic                          o_dropped,
    input wire logic                          o_last
);

    import drr_pkg::*;

    // a dropped beat is always the only and final beat of its insert
    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> o_last)
        else $error("dropped beat without last");

    // a dropped beat follows an accepted insert directly
    a_drop_after_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped)
        |-> $past(start && !busy && (i_operation == OP_INSERT)))
        else $error("dropped beat without a preceding insert");

    // release beats only come out of a walk
    a_release_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dropped) |-> $past(busy))
        else $error("release beat outside a walk");

    // reset leaves the block idle with nothing on the result channel
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("block not idle after reset");

endmodule : drr_chk

bind deferred_release_ring drr_chk u_drr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .o_dropped   (o_dropped),
    .o_last      (o_last)
);

`default_nettype wire
